// File: rtl/core/iss_pkg.sv
`timescale 1ns / 1ps

package iss_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 4;
    localparam int COUNT_W   = 5;
    localparam int REQ_W     = 3;

    localparam logic [WORD_W-1:0] ERR_WORD = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD_HEAD = 3'd0,
        REQ_ADD_TAIL = 3'd1,
        REQ_INSERT   = 3'd2,
        REQ_DELETE   = 3'd3,
        REQ_READ     = 3'd4,
        REQ_CLEAR    = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Shift command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic del;
    } cell_cmd_t;

endpackage

// File: rtl/core/iss_cell.sv
`timescale 1ns / 1ps

module iss_cell import iss_pkg::*; #(
    parameter int INDEX = 0,
    parameter int AT_W  = 4
) (
    input  logic              aclk,
    input  cell_cmd_t         cmd,
    input  logic [AT_W-1:0]   at,
    input  logic [WORD_W-1:0] new_word,
    input  logic [WORD_W-1:0] left_word,
    input  logic [WORD_W-1:0] right_word,
    output logic [WORD_W-1:0] word
);

    localparam logic [AT_W-1:0] MY_IDX = AT_W'(INDEX);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        if (cmd.ins) begin
            if (at == MY_IDX) begin
                word_next = new_word;
            end else if (at < MY_IDX) begin
                word_next = left_word;
            end
        end else if (cmd.del) begin
            if (at <= MY_IDX) begin
                word_next = right_word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// File: rtl/core/iss_ctrl.sv
`timescale 1ns / 1ps

module iss_ctrl import iss_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CNT_W = 5,
    parameter int AT_W  = 5
) (
    input  logic              fire,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [POS_W-1:0]  position,
    input  logic [CNT_W-1:0]  fill_count,
    output cell_cmd_t         cmd,
    output logic [AT_W-1:0]   at,
    output status_t           status,
    output logic              word_hit,
    output logic [CNT_W-1:0]  count_next
);

    logic [AT_W-1:0] cnt_ext;
    logic [AT_W-1:0] pos_ext;
    logic            full;
    logic            ins_ok;
    logic            del_ok;

    assign cnt_ext = AT_W'(fill_count);
    assign pos_ext = AT_W'(position);
    assign full    = (fill_count == CNT_W'(DEPTH));

    always_comb begin
        at         = pos_ext;
        status     = ST_OK;
        ins_ok     = 1'b0;
        del_ok     = 1'b0;
        word_hit   = 1'b0;
        count_next = fill_count;
        case (req_t'(req_type))
            REQ_ADD_HEAD, REQ_ADD_TAIL, REQ_INSERT: begin
                if (req_t'(req_type) == REQ_ADD_HEAD) begin
                    at = '0;
                end else if (req_t'(req_type) == REQ_ADD_TAIL) begin
                    at = cnt_ext;
                end
                if (full) begin
                    status = ST_FULL;
                end else if (at > cnt_ext) begin
                    status = ST_RANGE;
                end else begin
                    ins_ok     = 1'b1;
                    count_next = fill_count + CNT_W'(1);
                end
            end
            REQ_DELETE: begin
                if (pos_ext >= cnt_ext) begin
                    status = ST_RANGE;
                end else begin
                    del_ok     = 1'b1;
                    word_hit   = 1'b1;
                    count_next = fill_count - CNT_W'(1);
                end
            end
            REQ_READ: begin
                if (pos_ext >= cnt_ext) begin
                    status = ST_RANGE;
                end else begin
                    word_hit = 1'b1;
                end
            end
            REQ_CLEAR: begin
                count_next = '0;
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign cmd.ins = fire & ins_ok;
    assign cmd.del = fire & del_ok;

endmodule

// File: rtl/core/indexed_sequence_store_core.sv
`timescale 1ns / 1ps

// The result of an accepted request is registered and shown at the output in the cycle after it is taken.
// Throughput: one request per cycle while results are taken; all cells that move shift in the same cycle.
// The output register frees the input side as soon as the pending result is taken.
// Reset (aresetn low, synchronous) empties the store and drops any pending result;
// the cell words themselves are not cleared and are never read until written.
module indexed_sequence_store_core import iss_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [REQ_W-1:0]         s_req_type,
    input  logic signed [WORD_W-1:0] s_item_value,
    input  logic [POS_W-1:0]         s_position,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [WORD_W-1:0] m_read_value,
    output logic [1:0]               m_status,
    output logic [COUNT_W-1:0]       m_entry_count
);

    // Count must hold DEPTH itself; compares need room for any position too
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AT_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    // Only the first cells are reachable by position
    localparam int RD_N  = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

    logic                fire;
    cell_cmd_t           cmd;
    logic [AT_W-1:0]     at;
    status_t             status;
    logic                word_hit;
    logic [CNT_W-1:0]    count_next;
    logic [WORD_W-1:0]   rd_word;
    logic [WORD_W-1:0]   cell_word [DEPTH];

    logic [CNT_W-1:0]    count_reg;
    logic                m_valid_reg;
    logic [WORD_W-1:0]   m_read_value_reg;
    logic [1:0]          m_status_reg;
    logic [COUNT_W-1:0]  m_entry_count_reg;

    // Take a new request whenever the result slot is empty or is being drained
    assign s_ready = ~m_valid_reg | m_ready;
    assign fire    = s_valid & s_ready;

    // Decode the request against the current fill count
    iss_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W),
        .AT_W  (AT_W)
    ) u_ctrl (
        .fire       (fire),
        .req_type   (s_req_type),
        .position   (s_position),
        .fill_count (count_reg),
        .cmd        (cmd),
        .at         (at),
        .status     (status),
        .word_hit   (word_hit),
        .count_next (count_next)
    );

    // Chain of cells: on insert each cell above the gap takes its lower neighbour,
    // on delete each cell from the gap upwards takes its upper neighbour.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = s_item_value;
        end else begin : g_inner_l
            assign left_w = cell_word[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = cell_word[i];
        end else begin : g_inner_r
            assign right_w = cell_word[i+1];
        end

        iss_cell #(
            .INDEX (i),
            .AT_W  (AT_W)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .at         (at),
            .new_word   (s_item_value),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i])
        );
    end

    // Pick the addressed word before the chain shifts
    always_comb begin
        rd_word = ERR_WORD;
        for (int k = 0; k < RD_N; k++) begin
            if (s_position == POS_W'(k)) begin
                rd_word = cell_word[k];
            end
        end
    end

    // Hold the fill count; advance it only on an accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (fire) begin
            count_reg <= count_next;
        end
    end

    // Result valid flag: set on accept, drop once the result is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_read_value_reg  <= word_hit ? rd_word : ERR_WORD;
            m_status_reg      <= status;
            m_entry_count_reg <= COUNT_W'(count_next);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;

endmodule

// File: tb/sequence_store_checker.sv
`timescale 1ns / 1ps

module sequence_store_checker import iss_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [REQ_W-1:0]         s_req_type,
    input  logic signed [WORD_W-1:0] s_item_value,
    input  logic [POS_W-1:0]         s_position,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [WORD_W-1:0] m_read_value,
    input  logic [1:0]               m_status,
    input  logic [COUNT_W-1:0]       m_entry_count,
    output int                       fail_count,
    output int                       outstanding
);

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        status_t                  status;
        logic [COUNT_W-1:0]       entry_count;
    } store_reply_t;

    logic signed [WORD_W-1:0] shadow_words [DEPTH_DEF];
    logic [COUNT_W-1:0]       shadow_fill;
    store_reply_t             awaited_replies [$];
    int                       mismatches;

    initial begin
        shadow_fill = '0;
        mismatches  = 0;
        fail_count  = 0;
        outstanding = 0;
    end

    // Apply one request to the shadow sequence and return the reply it earns
    function automatic store_reply_t apply_request(input logic [REQ_W-1:0] req,
                                                   input logic signed [WORD_W-1:0] word,
                                                   input logic [POS_W-1:0] pos);
        store_reply_t reply;
        int           at;
        int           k;
        reply.read_value = ERR_WORD;
        reply.status     = ST_OK;
        case (req)
            REQ_ADD_HEAD, REQ_ADD_TAIL, REQ_INSERT: begin
                if (req == REQ_ADD_HEAD)
                    at = 0;
                else if (req == REQ_ADD_TAIL)
                    at = shadow_fill;
                else
                    at = pos;
                // full takes precedence over a bad position
                if (shadow_fill >= DEPTH_DEF) begin
                    reply.status = ST_FULL;
                end else if (at > shadow_fill) begin
                    reply.status = ST_RANGE;
                end else begin
                    for (k = shadow_fill; k > at; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[at] = word;
                    shadow_fill      = shadow_fill + 1'b1;
                end
            end
            REQ_DELETE: begin
                if (pos >= shadow_fill) begin
                    reply.status = ST_RANGE;
                end else begin
                    reply.read_value = shadow_words[pos];
                    for (k = pos; k + 1 < shadow_fill; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_fill = shadow_fill - 1'b1;
                end
            end
            REQ_READ: begin
                if (pos >= shadow_fill)
                    reply.status = ST_RANGE;
                else
                    reply.read_value = shadow_words[pos];
            end
            REQ_CLEAR: begin
                shadow_fill = '0;
            end
            default: begin
            end
        endcase
        reply.entry_count = shadow_fill;
        return reply;
    endfunction

    always @(posedge aclk) begin
        store_reply_t want;
        if (!aresetn) begin
            shadow_fill = '0;
            awaited_replies.delete();
        end else begin
            // Check the departing reply before logging the arriving request
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    $error("unexpected reply: read_value %0d status %0d entry_count %0d",
                           m_read_value, m_status, m_entry_count);
                    mismatches++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, m_read_value);
                        mismatches++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        mismatches++;
                    end
                    if (m_entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, m_entry_count);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                awaited_replies.push_back(apply_request(s_req_type, s_item_value, s_position));
        end
        outstanding <= awaited_replies.size();
        fail_count  <= mismatches;
    end

endmodule

// File: tb/tb_indexed_sequence_store_core.sv
`timescale 1ns / 1ps

module tb_indexed_sequence_store_core;
    import iss_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1700;
    // no idling on either side once this few random requests remain
    localparam int QUIET_TAIL   = 250;
    localparam int POS_MAX      = (1 << POS_W) - 1;

    // request codes the block has no meaning for; they must leave the store alone
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    // bias of the random request mix
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } op_mix_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [REQ_W-1:0]         s_req_type;
    logic signed [WORD_W-1:0] s_item_value;
    logic [POS_W-1:0]         s_position;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [WORD_W-1:0] m_read_value;
    logic [1:0]               m_status;
    logic [COUNT_W-1:0]       m_entry_count;

    int                       fail_count;
    int                       outstanding;
    int                       cycles = 0;
    logic                     src_gaps;
    logic                     sink_stalls;
    // last count the block reported; steers positions towards the live range
    logic [COUNT_W-1:0]       seen_count;

    always #5 aclk = ~aclk;

    indexed_sequence_store_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_item_value  (s_item_value),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

    sequence_store_checker u_store_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_item_value  (s_item_value),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // Watchdog: give up well past the slowest legal run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready)
            seen_count <= m_entry_count;
    end

    // Result side: while stalls are on, now and then hold ready low; otherwise keep it high
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_stalls && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 18);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Present one request and hold it until the block takes it. Valid is only
    // lowered when a gap is wanted, so back-to-back requests keep it high.
    task automatic issue_request(input logic [REQ_W-1:0] req,
                                 input logic signed [WORD_W-1:0] word,
                                 input logic [POS_W-1:0] pos);
        int gap;
        gap = 0;
        if (src_gaps && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 18);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_item_value <= word;
        s_position   <= pos;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and hold off until every outstanding reply has been taken
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Weighted draw; slots are head, tail, insert, delete, read, clear, spare
    function automatic logic [REQ_W-1:0] pick_req(input op_mix_t mix);
        int weights [7];
        int roll;
        int slot;
        case (mix)
            MIX_GROW:   weights = '{26, 26, 26, 8, 10, 1, 3};
            MIX_SHRINK: weights = '{8, 8, 8, 50, 20, 2, 4};
            default:    weights = '{15, 15, 20, 20, 20, 4, 6};
        endcase
        roll = $urandom_range(0, 99);
        slot = 0;
        while (slot < 6 && roll >= weights[slot]) begin
            roll -= weights[slot];
            slot++;
        end
        case (slot)
            0:       return REQ_ADD_HEAD;
            1:       return REQ_ADD_TAIL;
            2:       return REQ_INSERT;
            3:       return REQ_DELETE;
            4:       return REQ_READ;
            5:       return REQ_CLEAR;
            default: return $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
        endcase
    endfunction

    // Mostly full-range random words, with the signed extremes sprinkled in
    function automatic logic signed [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return {1'b0, {(WORD_W-1){1'b1}}};
            1:       return {1'b1, {(WORD_W-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly within 0..count (count itself appends on insert), sometimes anywhere
    function automatic logic [POS_W-1:0] pick_position();
        int top_pos;
        top_pos = (seen_count > POS_MAX) ? POS_MAX : seen_count;
        if ($urandom_range(0, 4) != 0)
            return POS_W'($urandom_range(0, top_pos));
        return POS_W'($urandom_range(0, POS_MAX));
    endfunction

    initial begin
        int      left;
        int      chunk;
        int      n;
        op_mix_t mix;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = REQ_ADD_HEAD;
        s_item_value = '0;
        s_position   = '0;
        seen_count   = '0;
        src_gaps     = 1'b1;
        sink_stalls  = 1'b1;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: errors on an empty store, insert into an empty store,
        // append by insert at the count, middle and last deletes, spare codes,
        // clear, and deleting the only word
        issue_request(REQ_READ,     32'sd0,        4'd0);
        issue_request(REQ_DELETE,   32'sd0,        4'd15);
        issue_request(REQ_INSERT,   32'sd5,        4'd1);
        issue_request(REQ_INSERT,   32'h7FFFFFFF,  4'd0);
        issue_request(REQ_ADD_HEAD, 32'h80000000,  4'd9);
        issue_request(REQ_ADD_TAIL, -32'sd1,       4'd0);
        issue_request(REQ_INSERT,   32'sd0,        4'd3);
        issue_request(REQ_INSERT,   32'sd77,       4'd5);
        issue_request(REQ_INSERT,   32'h55555555,  4'd1);
        issue_request(REQ_READ,     32'sd0,        4'd4);
        issue_request(REQ_READ,     32'sd0,        4'd0);
        issue_request(REQ_READ,     32'sd0,        4'd5);
        issue_request(REQ_DELETE,   32'sd0,        4'd2);
        issue_request(REQ_DELETE,   32'sd0,        4'd3);
        issue_request(REQ_SPARE_LO, 32'sd123,      4'd0);
        issue_request(REQ_SPARE_HI, 32'sd456,      4'd1);
        issue_request(REQ_CLEAR,    32'sd0,        4'd0);
        issue_request(REQ_DELETE,   32'sd0,        4'd0);
        issue_request(REQ_ADD_TAIL, 32'hAAAAAAAA,  4'd0);
        issue_request(REQ_DELETE,   32'sd0,        4'd0);
        issue_request(REQ_READ,     32'sd0,        4'd0);

        // Pause the sender until the store has answered everything
        settle();

        // Random: each chunk picks at random a filling mix (towards full), a draining mix
        // (towards empty) or an even mix, each with its own idling pattern
        left = RANDOM_ITEMS;
        while (left > 0) begin
            chunk = $urandom_range(40, 120);
            if (chunk > left)
                chunk = left;
            mix = op_mix_t'($urandom_range(0, 2));
            if (left <= QUIET_TAIL) begin
                src_gaps    = 1'b0;
                sink_stalls = 1'b0;
            end else begin
                n           = $urandom_range(0, 3);
                src_gaps    = n[0];
                sink_stalls = n[1];
            end
            for (n = 0; n < chunk; n++)
                issue_request(pick_req(mix), pick_value(), pick_position());
            left -= chunk;
            if (left > 0 && $urandom_range(0, 2) == 0)
                settle();
        end

        // Drain, let the block sit idle for a while, then judge
        settle();
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/iss_pkg.sv
rtl/core/iss_cell.sv
rtl/core/iss_ctrl.sv
rtl/core/indexed_sequence_store_core.sv
tb/sequence_store_checker.sv
tb/tb_indexed_sequence_store_core.sv
